>>> hdl/dmarf_pkg.sv
// Shared types and constants for the DMA controller register file.
// No dependencies; imported by every module under hdl/.
`timescale 1ns / 1ps
`default_nettype none
package dmarf_pkg;

   // Controller register numbers (port low nibble, or word index on controller 1)
   localparam logic [3:0] REG_COMMAND  = 4'd8;
   localparam logic [3:0] REG_SMASK    = 4'd10;
   localparam logic [3:0] REG_MODE     = 4'd11;
   localparam logic [3:0] REG_CLR_FF   = 4'd12;
   localparam logic [3:0] REG_MCLR     = 4'd13;
   localparam logic [3:0] REG_CLR_MASK = 4'd14;
   localparam logic [3:0] REG_WR_MASK  = 4'd15;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // What the memory stage does with the channel record
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_ADDR  = 3'd1,
      ACT_COUNT = 3'd2,
      ACT_PAGE  = 3'd3,
      ACT_MODE  = 3'd4
   } act_type;

   // One channel's record as held in the channel memory
   typedef struct packed {
      logic [15:0] base_address;
      logic [15:0] base_count;
      logic [7:0]  page_value;
      logic [5:0]  mode_bits;
   } chan_rec_type;

   // Decoded access handed from the decode stage to the memory stage
   typedef struct packed {
      logic       rd;
      act_type    act;
      logic       hi_byte;
      logic [7:0] data;
      logic [2:0] ch;
      logic       known;
      logic       masked;
   } cmd_type;

   // Result beat fields
   typedef struct packed {
      logic [5:0]  channel_mode;
      logic        channel_masked;
      logic [16:0] channel_length;
      logic [23:0] channel_address;
      logic [2:0]  channel;
      logic        port_known;
      logic [7:0]  read_data;
   } rsp_type;

   // Page register ports 0x80-0x8F: bit 3 = present, bits 2:0 = channel
   function automatic logic [3:0] page_decode(input logic [3:0] nib);
      logic [3:0] res;
      case (nib)
         4'h7:    res = 4'b1000;  // 0x87 ch0
         4'h3:    res = 4'b1001;  // 0x83 ch1
         4'h1:    res = 4'b1010;  // 0x81 ch2
         4'h2:    res = 4'b1011;  // 0x82 ch3
         4'hF:    res = 4'b1100;  // 0x8F ch4
         4'hB:    res = 4'b1101;  // 0x8B ch5
         4'h9:    res = 4'b1110;  // 0x89 ch6
         4'hA:    res = 4'b1111;  // 0x8A ch7
         default: res = 4'b0000;
      endcase
      return res;
   endfunction

endpackage
`default_nettype wire

>>> hdl/dmarf_decode.sv
// Port decode, byte flip-flops and mask bits of the DMA register file.
// Depends on dmarf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmarf_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              operation,
   input  wire logic [7:0]        port,
   input  wire logic [7:0]        write_data,
   output dmarf_pkg::cmd_type     cmd
);
   import dmarf_pkg::*;

   logic [1:0] flipflop_ff, flipflop_in;
   logic [7:0] mask_ff, mask_in;
   logic       ctl_hit;
   logic       ctl;
   logic [3:0] r;
   logic [3:0] pdec;
   logic       page_hit;
   logic       rd;

   assign rd = (operation == OP_READ);

   always_comb begin
      ctl_hit  = 1'b0;
      ctl      = 1'b0;
      r        = port[3:0];
      pdec     = page_decode(port[3:0]);
      page_hit = (port[7:4] == 4'h8) && pdec[3];
      if (port[7:4] == 4'h0) begin
         ctl_hit = 1'b1;
      end else if (port[7:5] == 3'b110) begin
         ctl_hit = 1'b1;
         ctl     = 1'b1;
         r       = port[4:1];
      end
   end

   always_comb begin
      flipflop_in = flipflop_ff;
      mask_in     = mask_ff;
      cmd.rd      = rd;
      cmd.act     = ACT_NONE;
      cmd.hi_byte = 1'b0;
      cmd.data    = write_data;
      cmd.ch      = 3'd0;
      cmd.known   = ctl_hit || page_hit;
      if (ctl_hit) begin
         if (!r[3]) begin
            cmd.act          = r[0] ? ACT_COUNT : ACT_ADDR;
            cmd.ch           = {ctl, r[2:1]};
            cmd.hi_byte      = flipflop_ff[ctl];
            flipflop_in[ctl] = ~flipflop_ff[ctl];
         end else if (!rd) begin
            case (r)
               REG_SMASK: begin
                  cmd.ch          = {ctl, write_data[1:0]};
                  mask_in[cmd.ch] = write_data[2];
               end
               REG_MODE: begin
                  cmd.ch  = {ctl, write_data[1:0]};
                  cmd.act = ACT_MODE;
               end
               REG_CLR_FF: flipflop_in[ctl] = 1'b0;
               REG_MCLR: begin
                  flipflop_in[ctl]          = 1'b0;
                  mask_in[{ctl, 2'b00} +: 4] = 4'b1111;
               end
               REG_CLR_MASK: mask_in[{ctl, 2'b00} +: 4] = 4'b0000;
               REG_WR_MASK:  mask_in[{ctl, 2'b00} +: 4] = write_data[3:0];
               default: ;  // command and request writes: no visible effect
            endcase
         end
      end else if (page_hit) begin
         cmd.act = ACT_PAGE;
         cmd.ch  = pdec[2:0];
      end
      cmd.masked = mask_in[cmd.ch];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flipflop_ff <= '0;
         mask_ff     <= '1;
      end else if (accept) begin
         flipflop_ff <= flipflop_in;
         mask_ff     <= mask_in;
      end
   end

endmodule
`default_nettype wire

>>> hdl/dmarf_chan_mem.sv
// Channel record memory with read-modify-write stage and write-to-read forwarding.
// Depends on dmarf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dmarf_chan_mem (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic              advance,
   input  wire dmarf_pkg::cmd_type cmd,
   output logic                   s1_valid,
   output dmarf_pkg::rsp_type     s1_rsp
);
   import dmarf_pkg::*;

   chan_rec_type mem [8];
   logic [7:0]   entry_valid_ff, entry_valid_in;
   chan_rec_type rd_rec_ff;
   logic         rd_ok_ff;
   cmd_type      cmd_ff;
   logic         valid_ff;
   chan_rec_type cur_rec;
   chan_rec_type new_rec;
   logic         wr_en;
   logic [7:0]   rdata;

   assign cur_rec = rd_ok_ff ? rd_rec_ff : '0;

   always_comb begin
      new_rec = cur_rec;
      rdata   = 8'd0;
      case (cmd_ff.act)
         ACT_ADDR: begin
            if (cmd_ff.hi_byte) begin
               rdata = cur_rec.base_address[15:8];
               if (!cmd_ff.rd) new_rec.base_address[15:8] = cmd_ff.data;
            end else begin
               rdata = cur_rec.base_address[7:0];
               if (!cmd_ff.rd) new_rec.base_address[7:0] = cmd_ff.data;
            end
         end
         ACT_COUNT: begin
            if (cmd_ff.hi_byte) begin
               rdata = cur_rec.base_count[15:8];
               if (!cmd_ff.rd) new_rec.base_count[15:8] = cmd_ff.data;
            end else begin
               rdata = cur_rec.base_count[7:0];
               if (!cmd_ff.rd) new_rec.base_count[7:0] = cmd_ff.data;
            end
         end
         ACT_PAGE: begin
            rdata = cur_rec.page_value;
            if (!cmd_ff.rd) new_rec.page_value = cmd_ff.data;
         end
         ACT_MODE: new_rec.mode_bits = cmd_ff.data[7:2];
         default: ;
      endcase
   end

   assign wr_en = valid_ff && advance && !cmd_ff.rd && (cmd_ff.act != ACT_NONE);

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (wr_en) entry_valid_in[cmd_ff.ch] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[cmd_ff.ch] <= new_rec;
      if (accept) begin
         cmd_ff <= cmd;
         // same-entry write in this cycle is forwarded past the memory
         if (wr_en && cmd_ff.ch == cmd.ch) begin
            rd_rec_ff <= new_rec;
            rd_ok_ff  <= 1'b1;
         end else begin
            rd_rec_ff <= mem[cmd.ch];
            rd_ok_ff  <= entry_valid_ff[cmd.ch];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         valid_ff       <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         if (advance) valid_ff <= accept;
      end
   end

   assign s1_valid = valid_ff;

   always_comb begin
      s1_rsp.read_data  = cmd_ff.rd ? rdata : 8'd0;
      s1_rsp.port_known = cmd_ff.known;
      s1_rsp.channel    = cmd_ff.ch;
      if (!cmd_ff.ch[2]) begin
         s1_rsp.channel_address = {new_rec.page_value, new_rec.base_address};
      end else begin
         s1_rsp.channel_address = {new_rec.page_value[7:1], new_rec.base_address, 1'b0};
      end
      s1_rsp.channel_length = {1'b0, new_rec.base_count} + 17'd1;
      s1_rsp.channel_masked = cmd_ff.masked;
      s1_rsp.channel_mode   = new_rec.mode_bits;
   end

endmodule
`default_nettype wire

>>> hdl/isa_dma_register_file.sv
// Top level of the PC DMA controller pair register file.
// Depends on dmarf_pkg, dmarf_decode and dmarf_chan_mem.
`timescale 1ns / 1ps
`default_nettype none
// Register side of the two cascaded 8237 DMA controllers (ports 0x00-0x0F and
// 0xC0-0xDF) and the eight page registers (0x81-0x8F). Every request beat is one
// port access and yields exactly one response beat describing the touched
// channel. Throughput is one access per cycle unless rsp_tready stalls the output.
// Decode and the channel memory read are registered on request accept; the
// read-modify-write of the channel record works on that registered read, and
// its result sits in the output register. Back-to-back accesses to the same
// channel are forwarded around the memory. No clearing pass is needed after reset.
module isa_dma_register_file (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // port[7:0], write_data[15:8]
   input  wire logic        req_tuser,  // operation (0 write, 1 read)
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata   // read_data[7:0], port_known[8], channel[11:9],
                                        // channel_address[35:12], channel_length[52:36],
                                        // channel_masked[53], channel_mode[59:54]
);
   import dmarf_pkg::*;

   logic    advance;
   logic    accept;
   cmd_type cmd;
   logic    s1_valid;
   rsp_type s1_rsp;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !reset;
   assign accept     = req_tvalid && req_tready;

   dmarf_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .operation  (req_tuser),
      .port       (req_tdata[7:0]),
      .write_data (req_tdata[15:8]),
      .cmd        (cmd)
   );

   dmarf_chan_mem u_chan_mem (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .advance  (advance),
      .cmd      (cmd),
      .s1_valid (s1_valid),
      .s1_rsp   (s1_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) rsp_ff <= s1_rsp;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff};

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for isa_dma_register_file: random and directed port accesses,
// every response beat checked against a scoreboard that tracks the controller state.
// Depends on dmarf_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module testbench;
   import dmarf_pkg::*;

   // Page register port of a channel (74LS612 layout)
   function automatic logic [7:0] page_port(input int unsigned ch);
      case (ch)
         0:       return 8'h87;
         1:       return 8'h83;
         2:       return 8'h81;
         3:       return 8'h82;
         4:       return 8'h8F;
         5:       return 8'h8B;
         6:       return 8'h89;
         default: return 8'h8A;
      endcase
   endfunction

   // Port of register r on controller 0 (byte ports), or its even port on controller 1 (word ports)
   function automatic logic [7:0] ctl_port(input logic ctl, input logic [3:0] r);
      return ctl ? 8'hC0 + {3'b000, r, 1'b0} : {4'h0, r};
   endfunction

   class dma_reg_scoreboard;
      logic        ff_hi [2];
      logic [15:0] addr_reg [8];
      logic [15:0] count_reg [8];
      logic [7:0]  page_reg [8];
      logic [5:0]  mode_reg [8];
      logic        mask_reg [8];
      logic [7:0]  cmd_reg [2];
      rsp_type     expected_q [$];
      int unsigned errors;

      function new();
         for (int k = 0; k < 8; k++) begin
            addr_reg[k] = '0;
            count_reg[k] = '0;
            page_reg[k] = '0;
            mode_reg[k] = '0;
            mask_reg[k] = 1'b1;
         end
         ff_hi[0] = 1'b0;
         ff_hi[1] = 1'b0;
         cmd_reg[0] = '0;
         cmd_reg[1] = '0;
         errors = 0;
      endfunction

      // One controller register access; ch is left at 0 when no channel is concerned
      function logic [7:0] ctl_access(input logic ctl, input logic [3:0] r, input logic rd,
                                      input logic [7:0] d, output logic [2:0] ch);
         logic [15:0] w;
         logic [7:0]  rbyte;
         rbyte = 8'h00;
         ch = 3'd0;
         if (r < 4'd8) begin
            ch = {ctl, r[2:1]};
            w = r[0] ? count_reg[ch] : addr_reg[ch];
            if (rd)
               rbyte = ff_hi[ctl] ? w[15:8] : w[7:0];
            else if (ff_hi[ctl])
               w[15:8] = d;
            else
               w[7:0] = d;
            if (r[0])
               count_reg[ch] = w;
            else
               addr_reg[ch] = w;
            ff_hi[ctl] = ~ff_hi[ctl];
         end else if (!rd) begin
            case (r)
               REG_COMMAND: cmd_reg[ctl] = d;
               REG_SMASK: begin
                  ch = {ctl, d[1:0]};
                  mask_reg[ch] = d[2];
               end
               REG_MODE: begin
                  ch = {ctl, d[1:0]};
                  mode_reg[ch] = d[7:2];
               end
               REG_CLR_FF: ff_hi[ctl] = 1'b0;
               REG_MCLR: begin
                  ff_hi[ctl] = 1'b0;
                  cmd_reg[ctl] = '0;
                  for (int k = 0; k < 4; k++)
                     mask_reg[{ctl, k[1:0]}] = 1'b1;
               end
               REG_CLR_MASK: begin
                  for (int k = 0; k < 4; k++)
                     mask_reg[{ctl, k[1:0]}] = 1'b0;
               end
               REG_WR_MASK: begin
                  for (int k = 0; k < 4; k++)
                     mask_reg[{ctl, k[1:0]}] = d[k];
               end
               default: ;
            endcase
         end
         return rbyte;
      endfunction

      function rsp_type predict_access(input logic op, input logic [7:0] port,
                                       input logic [7:0] d);
         rsp_type    res;
         logic       rd;
         logic [2:0] ch;
         logic [7:0] rbyte;
         rd = (op == OP_READ);
         ch = 3'd0;
         rbyte = 8'h00;
         res = '0;
         if (port < 8'h10) begin
            res.port_known = 1'b1;
            rbyte = ctl_access(1'b0, port[3:0], rd, d, ch);
         end else if (port >= 8'hC0 && port <= 8'hDF) begin
            // odd ports alias the even one below
            res.port_known = 1'b1;
            rbyte = ctl_access(1'b1, port[4:1], rd, d, ch);
         end else begin
            for (int k = 0; k < 8; k++) begin
               if (port == page_port(k)) begin
                  res.port_known = 1'b1;
                  ch = k[2:0];
                  if (rd)
                     rbyte = page_reg[k];
                  else
                     page_reg[k] = d;
               end
            end
         end
         res.read_data = rd ? rbyte : 8'h00;
         res.channel = ch;
         // word channels: page bit 0 dropped, word address shifted into bytes
         if (ch < 3'd4)
            res.channel_address = {page_reg[ch], addr_reg[ch]};
         else
            res.channel_address = {page_reg[ch][7:1], addr_reg[ch], 1'b0};
         res.channel_length = {1'b0, count_reg[ch]} + 17'd1;
         res.channel_masked = mask_reg[ch];
         res.channel_mode = mode_reg[ch];
         return res;
      endfunction

      function void note_access(input logic op, input logic [7:0] port, input logic [7:0] d);
         expected_q.push_back(predict_access(op, port, d));
      endfunction

      function void compare_field(input string name, input logic [31:0] exp_val,
                                  input logic [31:0] act_val);
         if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            errors++;
         end
      endfunction

      function void check_beat(input logic [63:0] beat);
         rsp_type exp_rsp;
         rsp_type act_rsp;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response beat, expected none, actual 0x%0h",
                     $time, beat);
            errors++;
            return;
         end
         exp_rsp = expected_q.pop_front();
         act_rsp = rsp_type'(beat[59:0]);
         compare_field("read_data", 32'(exp_rsp.read_data), 32'(act_rsp.read_data));
         compare_field("port_known", 32'(exp_rsp.port_known), 32'(act_rsp.port_known));
         compare_field("channel", 32'(exp_rsp.channel), 32'(act_rsp.channel));
         compare_field("channel_address", 32'(exp_rsp.channel_address),
                       32'(act_rsp.channel_address));
         compare_field("channel_length", 32'(exp_rsp.channel_length),
                       32'(act_rsp.channel_length));
         compare_field("channel_masked", 32'(exp_rsp.channel_masked),
                       32'(act_rsp.channel_masked));
         compare_field("channel_mode", 32'(exp_rsp.channel_mode),
                       32'(act_rsp.channel_mode));
         compare_field("tdata padding", 32'h0, 32'(beat[63:60]));
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   localparam logic [3:0]  REG_REQUEST = 4'd9;
   localparam int unsigned RANDOM_ITEMS = 700;
   localparam int unsigned CYCLE_LIMIT = 100000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;   // port[7:0], write_data[15:8]
   logic        req_tuser = 1'b0; // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;        // read_data, port_known, channel, channel_address,
                                  // channel_length, channel_masked, channel_mode

   dma_reg_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned items_sent = 0;
   int unsigned stall_mode = 0;

   isa_dma_register_file dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Response side: check accepted beats, stall on a slowly changing pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("isa_dma_register_file test failed");
         $finish;
      end
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready)
         sb.check_beat(rsp_tdata);
      if (cycle_count % 64 == 0)
         stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= (cycle_count % 4) != 3;
         2:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (cycle_count % 16) < 8;
      endcase
   end

   // One request beat; bursts of random length separated by random gaps
   task automatic send_access(input logic op, input logic [7:0] port, input logic [7:0] d);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {d, port};
      req_tuser <= op;
      do
         @(posedge clock);
      while (req_tready !== 1'b1);
      sb.note_access(op, port, d);
      burst_left--;
      items_sent++;
   endtask

   // Full programming of one channel with random values, then read back
   task automatic program_channel();
      int unsigned ch;
      logic        ctl;
      logic [1:0]  idx;
      logic [7:0]  d;
      ch = $urandom_range(0, 7);
      ctl = ch[2];
      idx = ch[1:0];
      send_access(OP_WRITE, ctl_port(ctl, REG_CLR_FF), 8'($urandom));
      send_access(OP_WRITE, ctl_port(ctl, {1'b0, idx, 1'b0}), 8'($urandom));
      send_access(OP_WRITE, ctl_port(ctl, {1'b0, idx, 1'b0}), 8'($urandom));
      send_access(OP_WRITE, ctl_port(ctl, {1'b0, idx, 1'b1}), 8'($urandom));
      send_access(OP_WRITE, ctl_port(ctl, {1'b0, idx, 1'b1}), 8'($urandom));
      send_access(OP_WRITE, page_port(ch), 8'($urandom));
      d = 8'($urandom);
      d[1:0] = idx;
      send_access(OP_WRITE, ctl_port(ctl, REG_MODE), d);
      d = 8'($urandom);
      d[1:0] = idx;
      send_access(OP_WRITE, ctl_port(ctl, REG_SMASK), d);
      if ($urandom_range(0, 1))
         send_access(OP_WRITE, ctl_port(ctl, REG_CLR_FF), 8'($urandom));
      send_access(OP_READ, ctl_port(ctl, {1'b0, idx, 1'b0}), 8'($urandom));
      send_access(OP_READ, ctl_port(ctl, {1'b0, idx, 1'b0}), 8'($urandom));
      send_access(OP_READ, ctl_port(ctl, {1'b0, idx, 1'b1}), 8'($urandom));
      send_access(OP_READ, ctl_port(ctl, {1'b0, idx, 1'b1}), 8'($urandom));
      send_access(OP_READ, page_port(ch), 8'($urandom));
   endtask

   initial begin
      int unsigned directed_end;
      int unsigned pick;
      logic [7:0]  port;
      logic        op;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset values, then extremes of address and count on a byte channel
      send_access(OP_READ, ctl_port(1'b0, 4'd0), 8'h00);
      send_access(OP_WRITE, ctl_port(1'b0, 4'd0), 8'hFF);
      send_access(OP_WRITE, ctl_port(1'b0, 4'd0), 8'h80);
      send_access(OP_WRITE, ctl_port(1'b0, 4'd1), 8'hFF);
      send_access(OP_WRITE, ctl_port(1'b0, 4'd1), 8'hFF);
      send_access(OP_WRITE, page_port(0), 8'hFF);
      send_access(OP_READ, page_port(0), 8'h00);
      send_access(OP_WRITE, ctl_port(1'b0, REG_MODE), 8'hFF);
      send_access(OP_WRITE, ctl_port(1'b0, REG_SMASK), 8'h00);
      send_access(OP_WRITE, ctl_port(1'b0, REG_WR_MASK), 8'h0A);
      send_access(OP_WRITE, ctl_port(1'b0, REG_COMMAND), 8'hA5);
      // status, temporary read and request write leave state alone
      send_access(OP_READ, ctl_port(1'b0, REG_COMMAND), 8'h00);
      send_access(OP_WRITE, ctl_port(1'b0, REG_REQUEST), 8'hFF);
      send_access(OP_READ, ctl_port(1'b0, REG_MCLR), 8'h00);
      send_access(OP_WRITE, ctl_port(1'b0, REG_MCLR), 8'h00);
      send_access(OP_WRITE, ctl_port(1'b0, REG_CLR_MASK), 8'h00);
      // word channel, high byte through the odd alias port
      send_access(OP_WRITE, ctl_port(1'b1, 4'd2), 8'h34);
      send_access(OP_WRITE, ctl_port(1'b1, 4'd2) + 8'd1, 8'h12);
      send_access(OP_WRITE, page_port(5), 8'h01);
      send_access(OP_READ, ctl_port(1'b1, 4'd2), 8'h00);
      send_access(OP_WRITE, ctl_port(1'b1, REG_MODE) + 8'd1, 8'hFE);
      send_access(OP_WRITE, ctl_port(1'b1, REG_WR_MASK), 8'hF0);
      // unknown ports
      send_access(OP_READ, 8'h10, 8'h00);
      send_access(OP_WRITE, 8'h80, 8'hFF);
      send_access(OP_READ, 8'hE0, 8'hFF);
      send_access(OP_WRITE, 8'hFF, 8'h55);
      directed_end = items_sent;

      while (items_sent < directed_end + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            program_channel();
         end else begin
            op = ($urandom_range(0, 2) == 0) ? OP_READ : OP_WRITE;
            case ($urandom_range(0, 4))
               0, 1:    port = 8'($urandom_range(8'h00, 8'h0F));
               2:       port = 8'($urandom_range(8'hC0, 8'hDF));
               3:       port = page_port($urandom_range(0, 7));
               default: port = 8'($urandom);
            endcase
            // noise: full port range
            if (pick >= 8)
               port = 8'($urandom);
            send_access(op, port, 8'($urandom));
         end
      end
      req_tvalid <= 1'b0;

      while (sb.pending() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0)
         $display("isa_dma_register_file test passed");
      else
         $display("isa_dma_register_file test failed");
      $finish;
   end
endmodule
